// File: hdl/assert_macros.svh
// Assertion helpers, clocked on a rising edge and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds -> cons holds in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in %m");

// ante holds -> cons holds in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in %m");

`endif

// File: hdl/drwl_pkg.sv
`default_nettype none

package drwl_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned SRV_W    = 6;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned TABLE_ENTRIES_DEF = 1024;
  localparam int unsigned MAX_SERVERS_DEF   = 64;

  localparam logic [CFG_W-1:0] SERVERS_RESET = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_READ_ACQ  = 3'd0,
    OP_WRITE_ACQ = 3'd1,
    OP_CERTIFY   = 3'd2,
    OP_READ_REL  = 3'd3,
    OP_WRITE_REL = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_BUSY  = 2'd1,
    STATUS_ERROR = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR  = 2'd0,
    ST_IDLE   = 2'd1,
    ST_UPDATE = 2'd2
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;   // zero one table entry, advance sweep
    logic accept;  // latch request word, read entry
    logic update;  // write back entry on success, load result word
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: hdl/drwl_if.sv
`default_nettype none

interface drwl_req_if;
  logic                             valid;
  logic                             ready;
  logic [drwl_pkg::OP_W-1:0]        operation;
  logic [drwl_pkg::IDX_W-1:0]       entry_index;
  logic [drwl_pkg::SRV_W-1:0]       server;
  logic                             certified;

  modport source (output valid, operation, entry_index, server, certified,
                  input ready);
  modport sink   (input valid, operation, entry_index, server, certified,
                  output ready);
endinterface

interface drwl_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [drwl_pkg::STATUS_W-1:0]    status;

  modport source (output valid, status, input ready);
  modport sink   (input valid, status, output ready);
endinterface

interface drwl_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [drwl_pkg::CFG_W-1:0]       data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: hdl/drwl_ctrl.sv
`default_nettype none

module drwl_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  output drwl_pkg::cmd_t      cmd,
  input  wire drwl_pkg::sts_t sts
);

  drwl_pkg::state_t state;
  drwl_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= drwl_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    case (state)
      drwl_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) begin
          state_next = drwl_pkg::ST_IDLE;
        end
      end
      drwl_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = drwl_pkg::ST_UPDATE;
        end
      end
      drwl_pkg::ST_UPDATE: begin
        // hold the entry until the result register can take the word
        if (sts.out_free) begin
          cmd.update = 1'b1;
          state_next = drwl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = drwl_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/drwl_dp.sv
`default_nettype none

module drwl_dp #(
  parameter int unsigned TABLE_ENTRIES = drwl_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned MAX_SERVERS   = drwl_pkg::MAX_SERVERS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire drwl_pkg::cmd_t                cmd,
  output drwl_pkg::sts_t                     sts,
  input  wire logic [drwl_pkg::OP_W-1:0]     in_operation,
  input  wire logic [drwl_pkg::IDX_W-1:0]    in_entry_index,
  input  wire logic [drwl_pkg::SRV_W-1:0]    in_server,
  input  wire logic                          in_certified,
  input  wire logic                          cfg_we,
  input  wire logic [drwl_pkg::CFG_W-1:0]    cfg_data,
  output logic                               out_valid,
  output logic [drwl_pkg::STATUS_W-1:0]      out_status,
  input  wire logic                          out_ready
);

  localparam int unsigned AW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned IDXW  = drwl_pkg::IDX_W;
  localparam int unsigned WORDW = MAX_SERVERS + 1;

  // entry word: {write flag, read flags}
  logic [WORDW-1:0] mem [TABLE_ENTRIES];

  logic [AW-1:0]                 clr_cnt;
  logic [AW+IDXW-1:0]            in_idx_ext;
  logic [AW-1:0]                 in_addr;
  logic                          in_idx_ok;

  logic [drwl_pkg::OP_W-1:0]     req_op;
  logic [AW-1:0]                 req_addr;
  logic                          req_idx_ok;
  logic [drwl_pkg::SRV_W-1:0]    req_srv;
  logic                          req_cert;
  logic [WORDW-1:0]              rd_word;

  logic [drwl_pkg::CFG_W-1:0]    servers_in_use;

  logic [drwl_pkg::CFG_W-1:0]    n_act;
  logic [MAX_SERVERS-1:0]        act_mask;
  logic [MAX_SERVERS-1:0]        srv_sel;
  logic                          srv_ok;
  logic [MAX_SERVERS-1:0]        rd_flags;
  logic                          rd_wr;
  logic [MAX_SERVERS-1:0]        flags_new;
  logic                          wr_new;
  logic                          upd_we;
  drwl_pkg::status_t             status_new;

  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [WORDW-1:0]              mem_wdata;

  assign in_idx_ext = (AW+IDXW)'(in_entry_index);
  assign in_addr    = in_idx_ext[AW-1:0];
  assign in_idx_ok  = (32'(in_entry_index) < 32'(TABLE_ENTRIES));

  assign sts.clear_done = (clr_cnt == AW'(TABLE_ENTRIES - 1));
  assign sts.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      servers_in_use <= drwl_pkg::SERVERS_RESET;
    end else if (cfg_we) begin
      servers_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_op     <= in_operation;
      req_addr   <= in_addr;
      req_idx_ok <= in_idx_ok;
      req_srv    <= in_server;
      req_cert   <= in_certified;
      rd_word    <= mem[in_addr];
    end
  end

  assign rd_flags = rd_word[MAX_SERVERS-1:0];
  assign rd_wr    = rd_word[MAX_SERVERS];

  always_comb begin
    // register value clamped to 1..MAX_SERVERS
    if (servers_in_use == '0) begin
      n_act = drwl_pkg::CFG_W'(1);
    end else if (servers_in_use > drwl_pkg::CFG_W'(MAX_SERVERS)) begin
      n_act = drwl_pkg::CFG_W'(MAX_SERVERS);
    end else begin
      n_act = servers_in_use;
    end
    for (int i = 0; i < MAX_SERVERS; i++) begin
      act_mask[i] = (drwl_pkg::CFG_W'(i) < n_act);
      srv_sel[i]  = (req_srv == drwl_pkg::SRV_W'(i));
    end
    srv_ok = (drwl_pkg::CFG_W'(req_srv) < n_act);
  end

  always_comb begin
    status_new = drwl_pkg::STATUS_ERROR;
    flags_new  = rd_flags;
    wr_new     = rd_wr;
    upd_we     = 1'b0;
    if (req_idx_ok) begin
      case (req_op)
        drwl_pkg::OP_READ_ACQ: begin
          if (!srv_ok) begin
            status_new = drwl_pkg::STATUS_ERROR;
          end else if ((rd_flags & srv_sel) == '0) begin
            flags_new  = rd_flags | srv_sel;
            upd_we     = 1'b1;
            status_new = drwl_pkg::STATUS_OK;
          end else begin
            status_new = drwl_pkg::STATUS_BUSY;
          end
        end
        drwl_pkg::OP_WRITE_ACQ: begin
          if (!rd_wr) begin
            wr_new     = 1'b1;
            upd_we     = 1'b1;
            status_new = drwl_pkg::STATUS_OK;
          end else begin
            status_new = drwl_pkg::STATUS_BUSY;
          end
        end
        drwl_pkg::OP_CERTIFY: begin
          if (!rd_wr) begin
            status_new = drwl_pkg::STATUS_ERROR;
          end else if ((rd_flags & act_mask) == '0) begin
            flags_new  = rd_flags | act_mask;
            upd_we     = 1'b1;
            status_new = drwl_pkg::STATUS_OK;
          end else begin
            status_new = drwl_pkg::STATUS_BUSY;
          end
        end
        drwl_pkg::OP_READ_REL: begin
          if (!srv_ok || (rd_flags & srv_sel) == '0) begin
            status_new = drwl_pkg::STATUS_ERROR;
          end else begin
            flags_new  = rd_flags & ~srv_sel;
            upd_we     = 1'b1;
            status_new = drwl_pkg::STATUS_OK;
          end
        end
        drwl_pkg::OP_WRITE_REL: begin
          if (!rd_wr || (req_cert && (rd_flags & act_mask) != act_mask)) begin
            status_new = drwl_pkg::STATUS_ERROR;
          end else begin
            if (req_cert) begin
              flags_new = rd_flags & ~act_mask;
            end
            wr_new     = 1'b0;
            upd_we     = 1'b1;
            status_new = drwl_pkg::STATUS_OK;
          end
        end
        default: begin
          status_new = drwl_pkg::STATUS_ERROR;
        end
      endcase
    end
  end

  always_comb begin
    if (cmd.clear) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '0;
    end else begin
      mem_we    = cmd.update && upd_we;
      mem_waddr = req_addr;
      mem_wdata = {wr_new, flags_new};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.update) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_status <= status_new;
    end
  end

endmodule

`default_nettype wire

// File: hdl/distributed_rw_lock_table.sv
// Flow: an accepted request word is latched and its entry read; the update
//   state then writes back the entry and loads the status word, waiting
//   while the result register is full. No new request is taken until the
//   write-back (read-modify-write of the entry table, registered read).
// Reset: synchronous; a clearing sweep zeroes every table entry, during
//   which no request is accepted.
`default_nettype none

`include "assert_macros.svh"

module distributed_rw_lock_table #(
  parameter int unsigned TABLE_ENTRIES = drwl_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned MAX_SERVERS   = drwl_pkg::MAX_SERVERS_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  drwl_req_if.sink   req,
  drwl_rsp_if.source rsp,
  drwl_cfg_if.sink   cfg
);

  drwl_pkg::cmd_t cmd;
  drwl_pkg::sts_t sts;

  assign cfg.ready = 1'b1;

  drwl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  drwl_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_SERVERS   (MAX_SERVERS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .in_operation   (req.operation),
    .in_entry_index (req.entry_index),
    .in_server      (req.server),
    .in_certified   (req.certified),
    .cfg_we         (cfg.valid && cfg.ready),
    .cfg_data       (cfg.data),
    .out_valid      (rsp.valid),
    .out_status     (rsp.status),
    .out_ready      (rsp.ready)
  );

  // no request word taken while the table is being cleared
  `ASSERT_SAME(a_no_accept_in_clear, clk, rst, cmd.clear, !req.ready)
  // one request in flight: an accepted word blocks the next cycle
  `ASSERT_NEXT(a_one_in_flight, clk, rst, req.valid && req.ready, !req.ready)
  // a write-back always presents a result word
  `ASSERT_NEXT(a_update_gives_word, clk, rst, cmd.update, rsp.valid)

endmodule

`default_nettype wire
